// ----- rtl/byte_pattern_search_top_macros.svh -----
// ----------------------------------------------------------------------------
// Byte pattern search assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_SEARCH_TOP_MACROS_SVH
`define BYTE_PATTERN_SEARCH_TOP_MACROS_SVH

// expression holds at every clock edge outside reset
`define BPS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent at an edge implies consequent at the next edge
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte pattern search package
// Field widths, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int OFFSET_W   = 16;
  localparam int PATTERN_W  = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_FORWARD = 2'd2;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic                too_long;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/byte_pattern_search_top.sv -----
// The marked byte is registered in the input stage; its result is then queued as valid.
// Throughput: one byte per cycle while in_stall is low; the window compare is combinational.
// Results leave through a two-entry queue, so bytes keep flowing while one waits.
// Reset (synchronous, active low) clears the search state and the result queue,
// and returns the registers to pattern 0, length 1, forward search.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_pattern_search_top_macros.svh"
// ----------------------------------------------------------------------------
// Byte pattern search top level
// Streams a buffer byte by byte and reports the first or last match offset.
// ----------------------------------------------------------------------------
module byte_pattern_search_top #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_LENGTH  = 65536
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // byte input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bps_pkg::BYTE_W-1:0]        in_data_byte,
  input  wire logic                              in_last_byte,
  // result output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_found,
  output logic [bps_pkg::OFFSET_W-1:0]           out_match_offset,
  output logic                                   out_too_long,
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int BW     = bps_pkg::BYTE_W;
  localparam int LW     = bps_pkg::LEN_W;
  localparam int OW     = bps_pkg::OFFSET_W;
  localparam int WIN_W  = BW * MAX_PATTERN;
  localparam int SEEN_W = $clog2(MAX_LENGTH + 2);

  // configuration registers
  logic [bps_pkg::PATTERN_W-1:0] pattern_r;
  logic [LW-1:0]                 length_r;
  logic                          forward_r;

  // input stage
  logic          vld_r;
  logic [BW-1:0] byte_r;
  logic          last_r;

  // search state
  logic [WIN_W-1:0]  win_r,    win_nxt;
  logic [SEEN_W-1:0] seen_r,   seen_nxt;
  logic              mseen_r,  mseen_nxt;
  logic [OW-1:0]     mstart_r, mstart_nxt;

  logic [LW-1:0]     used_len;
  logic [SEEN_W-1:0] seen_inc;
  logic [SEEN_W-1:0] start_pos;
  logic [WIN_W-1:0]  win_shift;
  logic              hit;

  // result queue
  bps_pkg::result_t q_r [2];
  bps_pkg::result_t result;
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [2:0]       occupancy;
  logic             push;
  logic             pop;
  logic             in_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= LW'(1);
      forward_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bps_pkg::CFG_PATTERN_BYTES:  pattern_r <= cfg_data;
        bps_pkg::CFG_PATTERN_LENGTH: length_r  <= cfg_data[LW-1:0];
        bps_pkg::CFG_SEARCH_FORWARD: forward_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp the length into 1..MAX_PATTERN
  always_comb begin
    used_len = length_r;
    if (length_r == '0) begin
      used_len = LW'(1);
    end else if (length_r > LW'(MAX_PATTERN)) begin
      used_len = LW'(MAX_PATTERN);
    end
  end

  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign win_shift = (win_r << BW) | WIN_W'(byte_r);
  assign seen_inc  = seen_r + SEEN_W'(1);
  assign start_pos = seen_inc - SEEN_W'(used_len);

  bps_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .window  (win_shift),
    .pattern (pattern_r[WIN_W-1:0]),
    .len     (used_len),
    .hit     (hit)
  );

  always_comb begin
    win_nxt    = win_r;
    seen_nxt   = seen_r;
    mseen_nxt  = mseen_r;
    mstart_nxt = mstart_r;
    if (seen_r < SEEN_W'(MAX_LENGTH)) begin
      win_nxt  = win_shift;
      seen_nxt = seen_inc;
      if (seen_inc >= SEEN_W'(used_len) && hit && (!forward_r || !mseen_r)) begin
        mstart_nxt = OW'(start_pos);
        mseen_nxt  = 1'b1;
      end
    end else begin
      // drop bytes past the limit and mark the buffer truncated
      seen_nxt = SEEN_W'(MAX_LENGTH + 1);
    end
  end

  always_comb begin
    result.found        = mseen_nxt;
    result.match_offset = mseen_nxt ? mstart_nxt : '0;
    result.too_long     = seen_nxt > SEEN_W'(MAX_LENGTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      mseen_r  <= 1'b0;
      mstart_r <= '0;
    end else if (vld_r) begin
      if (last_r) begin
        seen_r   <= '0;
        mseen_r  <= 1'b0;
        mstart_r <= '0;
      end else begin
        seen_r   <= seen_nxt;
        mseen_r  <= mseen_nxt;
        mstart_r <= mstart_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (vld_r) begin
      win_r <= last_r ? '0 : win_nxt;
    end
  end

  assign push = vld_r && last_r;
  assign pop  = out_valid && !out_stall;

  // hold input while a byte taken now could find the queue full
  assign occupancy = {1'b0, count_r} + {2'b00, push} - {2'b00, pop};
  assign in_stall  = occupancy >= 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= occupancy[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= result;
    end
  end

  assign out_valid        = count_r != 2'd0;
  assign out_found        = q_r[rd_ptr_r].found;
  assign out_match_offset = q_r[rd_ptr_r].match_offset;
  assign out_too_long     = q_r[rd_ptr_r].too_long;

  `BPS_ASSERT_ALWAYS(a_queue_bound, count_r <= 2'd2, "result queue beyond two entries")
  `BPS_ASSERT_ALWAYS(a_no_overflow, !push || occupancy <= 3'd2, "result pushed into full queue")
  `BPS_ASSERT_ALWAYS(a_offset_zero, !out_valid || out_found || out_match_offset == '0,
                     "offset nonzero without a match")
  `BPS_ASSERT_NEXT(a_clear_after, push, seen_r == '0 && !mseen_r, "search state not cleared")

endmodule
`default_nettype wire

// ----- rtl/bps_match.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte pattern search window compare
// Compares the newest bytes of the window against the pattern in parallel.
// ----------------------------------------------------------------------------
module bps_match #(
  parameter int MAX_PATTERN = 8
) (
  input  wire logic [8*MAX_PATTERN-1:0]  window,
  input  wire logic [8*MAX_PATTERN-1:0]  pattern,
  input  wire logic [bps_pkg::LEN_W-1:0] len,
  output logic                           hit
);

  localparam int BW = bps_pkg::BYTE_W;

  logic all_eq;

  // pattern byte i faces the window byte of age len-1-i
  always_comb begin
    hit    = 1'b0;
    all_eq = 1'b1;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      all_eq = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (window[BW*(l-1-i) +: BW] != pattern[BW*i +: BW]) begin
          all_eq = 1'b0;
        end
      end
      if (len == bps_pkg::LEN_W'(l)) begin
        hit = all_eq;
      end
    end
  end

endmodule
`default_nettype wire
